// ----- hdl/psa_pkg.sv -----
// Package for the priority alarm sequencer: field widths, request and
// priority codes, tone and blink timing constants and the result record.
// No dependencies; every other file of the block imports it.
package psa_pkg;

    localparam int NUM_CODES_DEF = 16;

    localparam int REQ_W     = 2;
    localparam int CODE_W    = 4;
    localparam int SIL_W     = 16;
    localparam int TIME_W    = 32;
    localparam int PITCH_W   = 2;
    localparam int TLEN_W    = 11;
    localparam int PHASE_W   = 4;
    localparam int PRIO_W    = 2;
    localparam int LIMIT_W   = 4;

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic REG_LAST_HIGH   = 1'b0;
    localparam logic REG_LAST_MEDIUM = 1'b1;

    localparam logic [LIMIT_W-1:0] LAST_HIGH_RST   = 4'd4;
    localparam logic [LIMIT_W-1:0] LAST_MEDIUM_RST = 4'd9;

    typedef enum logic [REQ_W-1:0] {
        REQ_ACTIVATE   = 2'd0,
        REQ_DEACTIVATE = 2'd1,
        REQ_SILENCE    = 2'd2,
        REQ_TICK       = 2'd3
    } req_t;

    typedef enum logic [PRIO_W-1:0] {
        PRIO_HIGH   = 2'd0,
        PRIO_MEDIUM = 2'd1,
        PRIO_LOW    = 2'd2,
        PRIO_NONE   = 2'd3
    } prio_t;

    localparam logic [PITCH_W-1:0] PITCH_440 = 2'd0;
    localparam logic [PITCH_W-1:0] PITCH_660 = 2'd1;
    localparam logic [PITCH_W-1:0] PITCH_880 = 2'd2;

    localparam logic [TLEN_W-1:0] LEN_HIGH   = 11'd75;
    localparam logic [TLEN_W-1:0] LEN_MEDIUM = 11'd150;
    localparam logic [TLEN_W-1:0] LEN_LOW    = 11'd2000;

    localparam logic [TIME_W-1:0] GAP_SHORT      = 32'd125;
    localparam logic [TIME_W-1:0] GAP_MID        = 32'd250;
    localparam logic [TIME_W-1:0] GAP_LONG       = 32'd625;
    localparam logic [TIME_W-1:0] GAP_HIGH_PAUSE = 32'd6125;
    localparam logic [TIME_W-1:0] GAP_MED_PAUSE  = 32'd12250;
    localparam logic [TIME_W-1:0] BLINK_PERIOD   = 32'd250;

    localparam logic [PHASE_W-1:0] BLINK_STEPS    = 4'd10;
    localparam logic [PHASE_W-1:0] BLINK_HALF     = 4'd5;
    localparam logic [PHASE_W-1:0] MED_LAST_PHASE = 4'd2;

    localparam logic [TIME_W-1:0] TIME_NEVER = '1;
    localparam logic [TIME_W-1:0] DUE_WINDOW = 32'h7FFF_FFFF;

    typedef struct packed {
        logic               tone_start;
        logic [PITCH_W-1:0] tone_pitch;
        logic [TLEN_W-1:0]  tone_length_ms;
        logic               tone_stop;
        logic               red_write;
        logic               red_level;
        logic               yellow_write;
        logic               yellow_level;
        logic               show_alarm;
        logic [PRIO_W-1:0]  top_priority;
        logic [CODE_W-1:0]  top_alarm;
        logic               silenced;
    } result_t;

endpackage

// ----- hdl/psa_if.sv -----
// Handshake channels of the priority alarm sequencer: one for requests,
// one for results. Depends on psa_pkg for the field widths.
interface psa_item_if
    import psa_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [CODE_W-1:0] alarm_code;
    logic [SIL_W-1:0]  silence_ms;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, req_type, alarm_code, silence_ms, now_ms, input ready);
    modport sink   (input valid, req_type, alarm_code, silence_ms, now_ms, output ready);
endinterface

interface psa_result_if
    import psa_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               tone_start;
    logic [PITCH_W-1:0] tone_pitch;
    logic [TLEN_W-1:0]  tone_length_ms;
    logic               tone_stop;
    logic               red_write;
    logic               red_level;
    logic               yellow_write;
    logic               yellow_level;
    logic               show_alarm;
    logic [PRIO_W-1:0]  top_priority;
    logic [CODE_W-1:0]  top_alarm;
    logic               silenced;

    modport source (
        output valid, tone_start, tone_pitch, tone_length_ms, tone_stop, red_write,
               red_level, yellow_write, yellow_level, show_alarm, top_priority,
               top_alarm, silenced,
        input  ready
    );
    modport sink (
        input  valid, tone_start, tone_pitch, tone_length_ms, tone_stop, red_write,
               red_level, yellow_write, yellow_level, show_alarm, top_priority,
               top_alarm, silenced,
        output ready
    );
endinterface

// ----- hdl/priority_alarm_sequencer.sv -----
// Top level of the priority alarm sequencer: input register, alarm state
// update and result register, plus the two band limit registers on APB.
// Depends on psa_pkg and on the channel interfaces in psa_if.sv.

// The sequencer takes one transaction per clock while results are taken,
// and returns exactly one result per transaction. The request is captured
// in an input register; once the result register is free, the alarm mask,
// tone and blink state and the result register are all updated together.
// The throughput of one transaction per cycle when no result stalls is
// set by that single state update, which each transaction sees after the one
// before it. Back-pressure on the result channel holds the result register;
// one new transaction still enters the input register while a result waits,
// and the next one waits until the result is taken. The band limits are
// written over APB and must only change while no transaction is in flight.
module priority_alarm_sequencer
    import psa_pkg::*;
#(
    parameter int NUM_CODES = NUM_CODES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    psa_item_if.sink            item,
    psa_result_if.source        result
);

    localparam int CW = $clog2(NUM_CODES);

    // Configuration registers.
    logic [LIMIT_W-1:0] last_high_reg;
    logic [LIMIT_W-1:0] last_medium_reg;
    logic               cfg_wr;
    logic               cfg_idx;

    // Input register.
    logic               s1_valid_reg;
    logic [REQ_W-1:0]   s1_req_reg;
    logic [CODE_W-1:0]  s1_code_reg;
    logic [SIL_W-1:0]   s1_sil_reg;
    logic [TIME_W-1:0]  s1_now_reg;

    // Alarm state.
    logic [NUM_CODES-1:0] mask_reg,   mask_next;
    logic                 snd_reg,    snd_next;
    logic                 led_reg,    led_next;
    logic [PHASE_W-1:0]   tph_reg,    tph_next;
    logic [PHASE_W-1:0]   bph_reg,    bph_next;
    logic [TIME_W-1:0]    ntt_reg,    ntt_next;
    logic [TIME_W-1:0]    nbt_reg,    nbt_next;
    logic [TIME_W-1:0]    rat_reg,    rat_next;
    logic                 rap_reg,    rap_next;

    // Result register.
    logic                 res_valid_reg;
    result_t              res_reg,    res_next;

    // Handshake.
    logic                 out_free;
    logic                 s1_adv;
    logic                 item_fire;

    // Combinational helpers.
    logic [LIMIT_W-1:0]   med_lim;
    logic [NUM_CODES-1:0] code_sel;
    logic                 code_ok;
    logic                 code_hit;
    logic [CW-1:0]        top_new;
    logic [CW-1:0]        top_cur;
    logic [NUM_CODES-1:0] hi_sel;
    logic [NUM_CODES-1:0] mid_sel;
    logic [NUM_CODES-1:0] lo_sel;
    logic                 hi_act;
    logic                 mid_act;
    logic                 lo_act;
    logic                 rearm_fire;
    logic                 snd_eff;
    logic                 led_eff;
    logic [TIME_W-1:0]    nt_eff;
    logic [TIME_W-1:0]    nb_eff;
    logic [PHASE_W-1:0]   tph_eff;
    logic [PHASE_W-1:0]   bph_eff;
    prio_t                top_prio_cur;

    function automatic logic [CW-1:0] top_of(input logic [NUM_CODES-1:0] m);
        logic [CW-1:0] t;
        t = '0;
        for (int c = NUM_CODES - 1; c >= 1; c--) begin
            if (m[c]) begin
                t = CW'(c);
            end
        end
        return t;
    endfunction

    function automatic logic is_due(input logic [TIME_W-1:0] now,
                                    input logic [TIME_W-1:0] target);
        logic [TIME_W-1:0] diff;
        diff = now - target;
        return diff < DUE_WINDOW;
    endfunction

    function automatic prio_t prio_of(input logic [CW-1:0]      code,
                                      input logic [LIMIT_W-1:0] lh,
                                      input logic [LIMIT_W-1:0] med);
        prio_t p;
        if (code <= lh) begin
            p = PRIO_HIGH;
        end else if (code <= med) begin
            p = PRIO_MEDIUM;
        end else begin
            p = PRIO_LOW;
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // APB configuration port.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[PADDR_W-1];

    always_comb
    begin
        unique case (cfg_idx)
            REG_LAST_HIGH:   prdata = PDATA_W'(last_high_reg);
            REG_LAST_MEDIUM: prdata = PDATA_W'(last_medium_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            last_high_reg   <= LAST_HIGH_RST;
            last_medium_reg <= LAST_MEDIUM_RST;
        end else if (cfg_wr) begin
            if (cfg_idx == REG_LAST_HIGH) begin
                last_high_reg <= pwdata[LIMIT_W-1:0];
            end else begin
                last_medium_reg <= pwdata[LIMIT_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshake: the input register drains whenever the result register
    // is empty or being read.
    // ------------------------------------------------------------------
    assign out_free   = !res_valid_reg || result.ready;
    assign s1_adv     = s1_valid_reg && out_free;
    assign item.ready = !s1_valid_reg || out_free;
    assign item_fire  = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (item_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                res_valid_reg <= 1'b1;
            end else if (result.ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire) begin
            s1_req_reg  <= item.req_type;
            s1_code_reg <= item.alarm_code;
            s1_sil_reg  <= item.silence_ms;
            s1_now_reg  <= item.now_ms;
        end
        if (s1_adv) begin
            res_reg <= res_next;
        end
    end

    // ------------------------------------------------------------------
    // Band decode. A medium limit below the high limit empties the band.
    // ------------------------------------------------------------------
    assign med_lim = (last_medium_reg < last_high_reg) ? last_high_reg : last_medium_reg;

    always_comb
    begin
        for (int c = 0; c < NUM_CODES; c++) begin
            hi_sel[c]  = (c >= 1) && (c <= int'(last_high_reg));
            mid_sel[c] = (c > int'(last_high_reg)) && (c <= int'(med_lim));
            lo_sel[c]  = c > int'(med_lim);
        end
    end

    assign hi_act  = |(mask_reg & hi_sel);
    assign mid_act = |(mask_reg & mid_sel);
    assign lo_act  = |(mask_reg & lo_sel);

    assign code_ok  = (s1_code_reg != '0) && (int'(s1_code_reg) < NUM_CODES);
    assign code_sel = code_ok ? (NUM_CODES'(1) << s1_code_reg) : '0;
    assign code_hit = |(mask_reg & code_sel);

    assign top_cur      = top_of(mask_reg);
    assign top_prio_cur = prio_of(top_cur, last_high_reg, med_lim);

    // A pending rearm that has come due restarts the pattern before the tick.
    assign rearm_fire = rap_reg && is_due(s1_now_reg, rat_reg);
    assign snd_eff    = rearm_fire || snd_reg;
    assign led_eff    = rearm_fire || led_reg;
    assign nt_eff     = rearm_fire ? s1_now_reg : ntt_reg;
    assign nb_eff     = rearm_fire ? s1_now_reg : nbt_reg;
    assign tph_eff    = rearm_fire ? '0 : tph_reg;
    assign bph_eff    = rearm_fire ? '0 : bph_reg;

    // ------------------------------------------------------------------
    // State update and result for the transaction in the input register.
    // ------------------------------------------------------------------
    always_comb
    begin
        mask_next = mask_reg;
        snd_next  = snd_reg;
        led_next  = led_reg;
        tph_next  = tph_reg;
        bph_next  = bph_reg;
        ntt_next  = ntt_reg;
        nbt_next  = nbt_reg;
        rat_next  = rat_reg;
        rap_next  = rap_reg;
        res_next  = '0;

        unique case (req_t'(s1_req_reg))
            REQ_ACTIVATE:
            begin
                if (code_ok && !code_hit) begin
                    mask_next = mask_reg | code_sel;
                    led_next  = 1'b1;
                    // The new alarm outranks every active one.
                    if (!(|(mask_reg & (code_sel - NUM_CODES'(1))))) begin
                        snd_next  = 1'b1;
                        ntt_next  = s1_now_reg;
                        nbt_next  = s1_now_reg;
                        tph_next  = '0;
                        bph_next  = '0;
                        rap_next  = 1'b0;
                        rat_next  = TIME_NEVER;
                        res_next.show_alarm = 1'b1;
                    end
                end
            end
            REQ_DEACTIVATE:
            begin
                if (code_ok && code_hit) begin
                    mask_next = mask_reg & ~code_sel;
                    res_next.tone_stop = 1'b1;
                    if (prio_of(CW'(s1_code_reg), last_high_reg, med_lim) == PRIO_HIGH) begin
                        res_next.red_write = 1'b1;
                    end else begin
                        res_next.yellow_write = 1'b1;
                    end
                    if (top_of(mask_next) == '0) begin
                        snd_next = 1'b0;
                        led_next = 1'b0;
                        rap_next = 1'b0;
                        rat_next = TIME_NEVER;
                    end else if (top_of(mask_next) > CW'(s1_code_reg)) begin
                        snd_next = 1'b1;
                        led_next = 1'b1;
                        ntt_next = s1_now_reg;
                        nbt_next = s1_now_reg;
                        tph_next = '0;
                        bph_next = '0;
                        rap_next = 1'b0;
                        rat_next = TIME_NEVER;
                    end
                end
            end
            REQ_SILENCE:
            begin
                snd_next = 1'b0;
                res_next.tone_stop = 1'b1;
                rat_next = s1_now_reg + TIME_W'(s1_sil_reg);
                rap_next = 1'b1;
            end
            REQ_TICK:
            begin
                snd_next = snd_eff;
                led_next = led_eff;
                ntt_next = nt_eff;
                nbt_next = nb_eff;
                tph_next = tph_eff;
                bph_next = bph_eff;
                if (rearm_fire) begin
                    rap_next = 1'b0;
                    rat_next = TIME_NEVER;
                end
                if (snd_eff) begin
                    if (top_cur != '0) begin
                        if (is_due(s1_now_reg, nt_eff)) begin
                            res_next.tone_start = 1'b1;
                            unique case (top_prio_cur)
                                PRIO_HIGH:
                                begin
                                    res_next.tone_pitch     = PITCH_880;
                                    res_next.tone_length_ms = LEN_HIGH;
                                    tph_next = tph_eff + PHASE_W'(1);
                                    unique case (tph_eff)
                                        4'd2, 4'd7:
                                            ntt_next = s1_now_reg + GAP_MID;
                                        4'd4:
                                            ntt_next = s1_now_reg + GAP_LONG;
                                        4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8:
                                            ntt_next = s1_now_reg + GAP_SHORT;
                                        default:
                                        begin
                                            // End of the ten-pulse burst.
                                            ntt_next = s1_now_reg + GAP_HIGH_PAUSE;
                                            tph_next = '0;
                                        end
                                    endcase
                                end
                                PRIO_MEDIUM:
                                begin
                                    res_next.tone_pitch     = PITCH_660;
                                    res_next.tone_length_ms = LEN_MEDIUM;
                                    if (tph_eff < MED_LAST_PHASE) begin
                                        tph_next = tph_eff + PHASE_W'(1);
                                        ntt_next = s1_now_reg + GAP_MID;
                                    end else begin
                                        tph_next = '0;
                                        ntt_next = s1_now_reg + GAP_MED_PAUSE;
                                    end
                                end
                                default:
                                begin
                                    res_next.tone_pitch     = PITCH_440;
                                    res_next.tone_length_ms = LEN_LOW;
                                    ntt_next = TIME_NEVER;
                                    snd_next = 1'b0;
                                end
                            endcase
                        end
                    end else begin
                        snd_next = 1'b0;
                    end
                    if (led_eff && is_due(s1_now_reg, nb_eff)) begin
                        res_next.red_write    = 1'b1;
                        res_next.red_level    = hi_act && !bph_eff[0];
                        res_next.yellow_write = 1'b1;
                        if (mid_act) begin
                            res_next.yellow_level = bph_eff < BLINK_HALF;
                        end else begin
                            res_next.yellow_level = lo_act;
                        end
                        bph_next = (bph_eff >= BLINK_STEPS - PHASE_W'(1)) ?
                                   '0 : bph_eff + PHASE_W'(1);
                        nbt_next = s1_now_reg + BLINK_PERIOD;
                    end
                end
            end
            default:
            begin
                mask_next = mask_reg;
            end
        endcase

        top_new = top_of(mask_next);
        res_next.top_alarm    = CODE_W'(top_new);
        res_next.top_priority = (top_new == '0) ? PRIO_NONE :
                                prio_of(top_new, last_high_reg, med_lim);
        res_next.silenced     = !snd_next && (top_new != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mask_reg <= '0;
            snd_reg  <= 1'b0;
            led_reg  <= 1'b0;
            tph_reg  <= '0;
            bph_reg  <= '0;
            ntt_reg  <= '0;
            nbt_reg  <= '0;
            rat_reg  <= TIME_NEVER;
            rap_reg  <= 1'b0;
        end else if (s1_adv) begin
            mask_reg <= mask_next;
            snd_reg  <= snd_next;
            led_reg  <= led_next;
            tph_reg  <= tph_next;
            bph_reg  <= bph_next;
            ntt_reg  <= ntt_next;
            nbt_reg  <= nbt_next;
            rat_reg  <= rat_next;
            rap_reg  <= rap_next;
        end
    end

    // ------------------------------------------------------------------
    // Result channel.
    // ------------------------------------------------------------------
    assign result.valid          = res_valid_reg;
    assign result.tone_start     = res_reg.tone_start;
    assign result.tone_pitch     = res_reg.tone_pitch;
    assign result.tone_length_ms = res_reg.tone_length_ms;
    assign result.tone_stop      = res_reg.tone_stop;
    assign result.red_write      = res_reg.red_write;
    assign result.red_level      = res_reg.red_level;
    assign result.yellow_write   = res_reg.yellow_write;
    assign result.yellow_level   = res_reg.yellow_level;
    assign result.show_alarm     = res_reg.show_alarm;
    assign result.top_priority   = res_reg.top_priority;
    assign result.top_alarm      = res_reg.top_alarm;
    assign result.silenced       = res_reg.silenced;

endmodule

// ----- hdl/psa_checker.sv -----
// Port-level checks on the result channel of the priority alarm sequencer,
// bound to the top level. Depends on psa_pkg and psa_result_if.
module psa_checker
    import psa_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    psa_result_if.source result
);

    // A stalled result keeps its contents until it is taken.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=>
            result.valid && $stable(result.top_alarm) && $stable(result.tone_start)
            && $stable(result.tone_stop) && $stable(result.silenced))
        else $error("result changed while stalled");

    a_no_tone_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.tone_start |->
            result.tone_pitch == PITCH_440 && result.tone_length_ms == '0)
        else $error("tone fields set without a tone start");

    a_led_levels: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
            (result.red_write || !result.red_level)
            && (result.yellow_write || !result.yellow_level))
        else $error("LED level given without a write");

    // A newly shown alarm is reported as an active, unsilenced alarm with no tone stop.
    a_show_sounds: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.show_alarm |->
            result.top_alarm != '0 && !result.silenced
            && result.top_priority != PRIO_NONE && !result.tone_stop)
        else $error("shown alarm is not sounding");

    a_no_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.top_alarm == '0 |->
            result.top_priority == PRIO_NONE && !result.silenced && !result.tone_start)
        else $error("idle result reports an alarm");

endmodule

bind priority_alarm_sequencer psa_checker u_psa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .result (result)
);
